>>> design/assert_macros.svh
// assertion macros shared by the sequencer rtl
// expects signals named clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tpss_pkg.sv
// types and constants for the three point servo scan sequencer
// no dependencies
`timescale 1ns / 1ps

package tpss_pkg;

    localparam int ANGLE_BITS   = 8;
    localparam int PHASE_BITS   = 4;
    localparam int KIND_BITS    = 2;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_IDLE   = 4'd0,
        PH_MOVE_L = 4'd1,
        PH_READ_L = 4'd2,
        PH_MOVE_C = 4'd3,
        PH_READ_C = 4'd4,
        PH_MOVE_R = 4'd5,
        PH_READ_R = 4'd6,
        PH_RETURN = 4'd7,
        PH_DONE   = 4'd8
    } phase_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_TICK   = 2'd0,
        KIND_START  = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_TAKE   = 2'd3
    } kind_t;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_ANGLE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_ANGLE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_ANGLE    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_MS      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RETURN_MS      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SENSOR_PRESENT = 3'd5;

    // reset values
    localparam logic [ANGLE_BITS-1:0] LEFT_ANGLE_RESET   = 8'd150;
    localparam logic [ANGLE_BITS-1:0] CENTER_ANGLE_RESET = 8'd90;
    localparam logic [ANGLE_BITS-1:0] RIGHT_ANGLE_RESET  = 8'd30;
    localparam int                    SETTLE_MS_RESET    = 1000;
    localparam int                    RETURN_MS_RESET    = 300;

endpackage

>>> design/tpss_if.sv
// valid/ready channel interfaces for the sequencer: command words in, status words out
// depends on tpss_pkg
`timescale 1ns / 1ps

interface tpss_req_if
    import tpss_pkg::*;
#(
    parameter int DISTANCE_BITS = 10
) ();
    logic                     valid;
    logic                     ready;
    logic [KIND_BITS-1:0]     kind;
    logic [DISTANCE_BITS-1:0] distance_sample;

    modport source (output valid, kind, distance_sample, input ready);
    modport sink   (input valid, kind, distance_sample, output ready);
endinterface

interface tpss_rsp_if
    import tpss_pkg::*;
#(
    parameter int DISTANCE_BITS = 10
) ();
    logic                     valid;
    logic                     ready;
    logic [ANGLE_BITS-1:0]    servo_angle;
    logic                     servo_write;
    logic [PHASE_BITS-1:0]    phase;
    logic                     scan_done;
    logic [DISTANCE_BITS-1:0] left_distance;
    logic [DISTANCE_BITS-1:0] center_distance;
    logic [DISTANCE_BITS-1:0] right_distance;

    modport source (output valid, servo_angle, servo_write, phase, scan_done,
                    left_distance, center_distance, right_distance, input ready);
    modport sink   (input valid, servo_angle, servo_write, phase, scan_done,
                    left_distance, center_distance, right_distance, output ready);
endinterface

>>> design/tpss_out_skid.sv
// two-entry result buffer: output register plus skid register
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpss_out_skid #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  logic [WIDTH-1:0] up_data,
    output logic             dn_valid,
    input  logic             dn_ready,
    output logic [WIDTH-1:0] dn_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] main_data_reg, main_data_next;
    logic [WIDTH-1:0] skid_data_reg, skid_data_next;
    logic             up_accept;

    assign up_ready  = !skid_valid_reg;
    assign up_accept = up_valid && up_ready;
    assign dn_valid  = main_valid_reg;
    assign dn_data   = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (up_accept)
        begin
            if (!main_valid_reg || dn_ready)
            begin
                main_valid_next = 1'b1;
                main_data_next  = up_data;
            end
            else
            begin
                // receiver stalled: park the word
                skid_valid_next = 1'b1;
                skid_data_next  = up_data;
            end
        end
        else if (dn_ready)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    `ASSERT_SAME(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid full while output empty")
    `ASSERT_NEXT(a_skid_drains, skid_valid_reg && dn_ready, !skid_valid_reg && main_valid_reg, "skid word not moved forward")
    `ASSERT_NEXT(a_stall_parks, up_accept && main_valid_reg && !dn_ready, skid_valid_reg, "word lost on stall")

endmodule

>>> design/three_point_servo_scan_sequencer.sv
// three point servo scan sequencer, top level
// depends on tpss_pkg, tpss_if, tpss_out_skid and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// usage
//   req channel carries one command word: kind (tick, start, cancel, take) and the
//   current distance sample. every accepted word yields exactly one status word on
//   the rsp channel showing the servo angle, whether a servo command was issued,
//   the phase, the done flag and the three stored distances after that word
//   each status word is registered in the output buffer and held while rsp.ready is low
//   throughput: one word per cycle while req.ready is high; the whole state update
//   is one pass of logic from the accepted word into the state and result registers
//   stall: a two-entry output buffer lets one more word in while a status word
//   waits; req.ready drops only when both entries are full
//   config: cfg_we/cfg_index/cfg_data write one register per cycle; write only while
//   the sequencer is quiet (not enforced); indexes past the list are ignored
//   reset: phase idle, counter and stores zero, servo at 90 degrees, registers at
//   their defaults, output buffer empty
module three_point_servo_scan_sequencer
    import tpss_pkg::*;
#(
    parameter int DISTANCE_BITS = 10,
    parameter int WAIT_BITS     = 11
) (
    input  logic                    clk,
    input  logic                    rst_n,
    tpss_req_if.sink                req,
    tpss_rsp_if.source              rsp,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WAIT_BITS-1:0]    cfg_data
);

    localparam int RSP_BITS = ANGLE_BITS + 1 + PHASE_BITS + 1 + 3 * DISTANCE_BITS;

    // configuration registers
    logic [ANGLE_BITS-1:0] left_angle_reg;
    logic [ANGLE_BITS-1:0] center_angle_reg;
    logic [ANGLE_BITS-1:0] right_angle_reg;
    logic [WAIT_BITS-1:0]  settle_ms_reg;
    logic [WAIT_BITS-1:0]  return_ms_reg;
    logic                  sensor_present_reg;

    // sequencer state
    phase_t                   phase_reg, phase_next;
    logic [WAIT_BITS-1:0]     elapsed_reg, elapsed_next;
    logic [DISTANCE_BITS-1:0] left_reg, left_next;
    logic [DISTANCE_BITS-1:0] center_reg, center_next;
    logic [DISTANCE_BITS-1:0] right_reg, right_next;
    logic [ANGLE_BITS-1:0]    angle_reg, angle_next;
    logic                     servo_write;

    logic                     req_ready;
    logic                     req_accept;
    kind_t                    req_kind;
    logic [WAIT_BITS-1:0]     elapsed_inc;
    logic                     settle_over;
    logic                     return_over;
    logic [RSP_BITS-1:0]      rsp_word;
    logic [RSP_BITS-1:0]      rsp_out;

    assign req.ready  = req_ready;
    assign req_accept = req.valid && req_ready;
    assign req_kind   = kind_t'(req.kind);

    // saturating tick count; a wait ends once the count reaches its register
    assign elapsed_inc = (elapsed_reg == {WAIT_BITS{1'b1}}) ? elapsed_reg
                                                            : elapsed_reg + 1'b1;
    assign settle_over = elapsed_inc >= settle_ms_reg;
    assign return_over = elapsed_inc >= return_ms_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_angle_reg     <= LEFT_ANGLE_RESET;
            center_angle_reg   <= CENTER_ANGLE_RESET;
            right_angle_reg    <= RIGHT_ANGLE_RESET;
            settle_ms_reg      <= WAIT_BITS'(SETTLE_MS_RESET);
            return_ms_reg      <= WAIT_BITS'(RETURN_MS_RESET);
            sensor_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT_ANGLE:     left_angle_reg     <= cfg_data[ANGLE_BITS-1:0];
                CFG_CENTER_ANGLE:   center_angle_reg   <= cfg_data[ANGLE_BITS-1:0];
                CFG_RIGHT_ANGLE:    right_angle_reg    <= cfg_data[ANGLE_BITS-1:0];
                CFG_SETTLE_MS:      settle_ms_reg      <= cfg_data;
                CFG_RETURN_MS:      return_ms_reg      <= cfg_data;
                CFG_SENSOR_PRESENT: sensor_present_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (req_accept)
        begin
            unique case (req_kind)
                KIND_START:
                begin
                    // start only from idle
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next = PH_MOVE_L;
                    end
                end
                KIND_CANCEL, KIND_TAKE:
                begin
                    phase_next = PH_IDLE;
                end
                KIND_TICK:
                begin
                    unique case (phase_reg)
                        PH_MOVE_L: phase_next = PH_READ_L;
                        PH_READ_L: phase_next = settle_over ? PH_MOVE_C : PH_READ_L;
                        PH_MOVE_C: phase_next = PH_READ_C;
                        PH_READ_C: phase_next = settle_over ? PH_MOVE_R : PH_READ_C;
                        PH_MOVE_R: phase_next = PH_READ_R;
                        PH_READ_R: phase_next = settle_over ? PH_RETURN : PH_READ_R;
                        PH_RETURN: phase_next = return_over ? PH_DONE : PH_RETURN;
                        default:   phase_next = phase_reg; // idle and done ignore ticks
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // datapath outputs: servo command, tick counter, stored distances
    always_comb
    begin
        angle_next   = angle_reg;
        elapsed_next = elapsed_reg;
        left_next    = left_reg;
        center_next  = center_reg;
        right_next   = right_reg;
        servo_write  = 1'b0;
        if (req_accept)
        begin
            unique case (req_kind)
                KIND_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        left_next   = '0;
                        center_next = '0;
                        right_next  = '0;
                    end
                end
                KIND_CANCEL:
                begin
                    // re-center the servo from any phase
                    angle_next  = center_angle_reg;
                    servo_write = 1'b1;
                end
                KIND_TAKE:
                begin
                    angle_next = angle_reg;
                end
                KIND_TICK:
                begin
                    unique case (phase_reg)
                        PH_MOVE_L:
                        begin
                            angle_next   = left_angle_reg;
                            servo_write  = 1'b1;
                            elapsed_next = '0;
                        end
                        PH_MOVE_C:
                        begin
                            angle_next   = center_angle_reg;
                            servo_write  = 1'b1;
                            elapsed_next = '0;
                        end
                        PH_MOVE_R:
                        begin
                            angle_next   = right_angle_reg;
                            servo_write  = 1'b1;
                            elapsed_next = '0;
                        end
                        PH_READ_L:
                        begin
                            elapsed_next = elapsed_inc;
                            if (settle_over && sensor_present_reg)
                            begin
                                left_next = req.distance_sample;
                            end
                        end
                        PH_READ_C:
                        begin
                            elapsed_next = elapsed_inc;
                            if (settle_over && sensor_present_reg)
                            begin
                                center_next = req.distance_sample;
                            end
                        end
                        PH_READ_R:
                        begin
                            elapsed_next = elapsed_inc;
                            if (settle_over)
                            begin
                                if (sensor_present_reg)
                                begin
                                    right_next = req.distance_sample;
                                end
                                // last reading taken: head back to center
                                angle_next   = center_angle_reg;
                                servo_write  = 1'b1;
                                elapsed_next = '0;
                            end
                        end
                        PH_RETURN:
                        begin
                            elapsed_next = elapsed_inc;
                        end
                        default:
                        begin
                            elapsed_next = elapsed_reg;
                        end
                    endcase
                end
                default:
                begin
                    angle_next = angle_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            left_reg    <= '0;
            center_reg  <= '0;
            right_reg   <= '0;
            angle_reg   <= CENTER_ANGLE_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            left_reg    <= left_next;
            center_reg  <= center_next;
            right_reg   <= right_next;
            angle_reg   <= angle_next;
        end
    end

    // status word shows the state after the command
    assign rsp_word = {angle_next, servo_write, phase_next, (phase_next == PH_DONE),
                       left_next, center_next, right_next};

    tpss_out_skid #(
        .WIDTH (RSP_BITS)
    ) u_out_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req.valid),
        .up_ready (req_ready),
        .up_data  (rsp_word),
        .dn_valid (rsp.valid),
        .dn_ready (rsp.ready),
        .dn_data  (rsp_out)
    );

    assign {rsp.servo_angle, rsp.servo_write, rsp.phase, rsp.scan_done,
            rsp.left_distance, rsp.center_distance, rsp.right_distance} = rsp_out;

    `ASSERT_NEXT(a_cancel_centers, req_accept && req_kind == KIND_CANCEL, phase_reg == PH_IDLE && angle_reg == $past(center_angle_reg), "cancel did not re-center")
    `ASSERT_NEXT(a_phase_holds, !req_accept, phase_reg == $past(phase_reg), "phase moved without a command")
    `ASSERT_NEXT(a_start_clears, req_accept && req_kind == KIND_START && phase_reg == PH_IDLE, left_reg == '0 && center_reg == '0 && right_reg == '0 && phase_reg == PH_MOVE_L, "start did not clear stores")

endmodule
